// ===== hw/rtl/sv39ptw_pkg.sv =====
// Shared types and constants for the Sv39 page-table walker.
package sv39ptw_pkg;

  // Result kinds on the output channel.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Page fault codes.
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_INST  = 2'd1;
  localparam logic [1:0] FAULT_LOAD  = 2'd2;
  localparam logic [1:0] FAULT_STORE = 2'd3;

  // Access kinds of a translation request.
  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;

  // Input function codes.
  localparam logic FUNC_REQ  = 1'b0;
  localparam logic FUNC_RESP = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PAGING = 1'b0;
  localparam logic CFG_ROOT   = 1'b1;

  // PTE bit positions.
  localparam int PTE_V = 0;
  localparam int PTE_R = 1;
  localparam int PTE_W = 2;
  localparam int PTE_X = 3;
  localparam int PTE_A = 6;
  localparam int PTE_D = 7;

  localparam int PPN_W = 44;

  // Walk level, one-hot.
  typedef enum logic [3:0] {
    LVL_IDLE = 4'b0001,
    LVL_ROOT = 4'b0010,
    LVL_MID  = 4'b0100,
    LVL_LEAF = 4'b1000
  } level_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [63:0] wdata;
    logic [1:0]  fault;
    logic        last;
  } result_t;

endpackage

// ===== hw/rtl/sv39_page_table_walker.sv =====
// Sv39 page-table walker top level: input stage, walk control and result queue.
//
// The walker accepts one item per cycle while its result queue has room: either a
// translation request or a memory read response carrying a page-table entry. An accepted
// item is held in an input register, is evaluated against the walk state in a single pass of
// logic, and its results go into a four-entry result queue. Most items give one result; a
// successful leaf gives two (the A/D write-back, then the finished translation), which leave
// the queue one after the other. The input stage holds an item until the queue has two free
// entries, so the sustained rate is one item per cycle as long as the output side takes one
// result per cycle. Requests that arrive during a walk and responses that arrive while idle
// are dropped without a result. Configuration writes take effect at once and are expected
// only while the walker is idle.
module sv39_page_table_walker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [43:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [63:0] virt_addr,
  input  logic [1:0]  access_kind,
  input  logic [63:0] mem_data,
  input  logic        mem_ok,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [63:0] out_addr,
  output logic [63:0] write_data,
  output logic [1:0]  fault_code,
  output logic        last
);

  // Configuration registers.
  logic        paging_enable;
  logic [43:0] root_table_page;

  // Input stage.
  logic        s_valid;
  logic        s_func;
  logic [63:0] s_va;
  logic [1:0]  s_acc;
  logic [63:0] s_data;
  logic        s_ok;
  logic        fire;

  // Walk state.
  sv39ptw_pkg::level_t level;
  sv39ptw_pkg::level_t level_next;
  logic [63:0] saved_vaddr;
  logic [63:0] saved_vaddr_next;
  logic [1:0]  saved_access;
  logic [1:0]  saved_access_next;
  logic [63:0] entry_addr;
  logic [63:0] entry_addr_next;

  // Evaluation signals.
  sv39ptw_pkg::result_t r0;
  sv39ptw_pkg::result_t r1;
  sv39ptw_pkg::result_t q_out;
  logic        r0_valid;
  logic        r1_valid;
  logic        space2;
  logic [43:0] ppn;
  logic [43:0] done_ppn;
  logic        leaf_hit;
  logic        perm_fault;
  logic [1:0]  perm_code;
  logic [63:0] root_addr;
  logic [63:0] next_addr;
  logic [8:0]  next_vpn;
  logic [63:0] new_pte;

  assign fire     = s_valid && space2;
  assign in_ready = !s_valid || fire;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      paging_enable   <= 1'b0;
      root_table_page <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sv39ptw_pkg::CFG_PAGING: paging_enable   <= cfg_data[0];
        sv39ptw_pkg::CFG_ROOT:   root_table_page <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; refilled on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_func <= func;
      s_va   <= virt_addr;
      s_acc  <= access_kind;
      s_data <= mem_data;
      s_ok   <= mem_ok;
    end
  end

  // Address arithmetic; the low 12 bits of a table page are zero, so concatenation suffices.
  assign ppn       = s_data[53:10];
  assign root_addr = {8'b0, root_table_page, s_va[38:30], 3'b000};
  assign next_vpn  = (level == sv39ptw_pkg::LVL_ROOT) ? saved_vaddr[29:21] : saved_vaddr[20:12];
  assign next_addr = {8'b0, ppn, next_vpn, 3'b000};

  // Permission check for the leaf and the updated entry.
  always_comb begin
    perm_fault = 1'b0;
    perm_code  = sv39ptw_pkg::FAULT_NONE;
    new_pte    = s_data;
    new_pte[sv39ptw_pkg::PTE_A] = 1'b1;
    case (saved_access)
      sv39ptw_pkg::ACC_FETCH: begin
        perm_fault = !s_data[sv39ptw_pkg::PTE_X];
        perm_code  = sv39ptw_pkg::FAULT_INST;
      end
      sv39ptw_pkg::ACC_LOAD: begin
        perm_fault = !s_data[sv39ptw_pkg::PTE_R];
        perm_code  = sv39ptw_pkg::FAULT_LOAD;
      end
      sv39ptw_pkg::ACC_STORE: begin
        perm_fault = !s_data[sv39ptw_pkg::PTE_W];
        perm_code  = sv39ptw_pkg::FAULT_STORE;
        new_pte[sv39ptw_pkg::PTE_D] = 1'b1;
      end
      default: ;
    endcase
  end

  // Single-pass evaluation of the item in the input register.
  always_comb begin
    r0                = '0;
    r1                = '0;
    r0_valid          = 1'b0;
    r1_valid          = 1'b0;
    leaf_hit          = 1'b0;
    done_ppn          = ppn;
    level_next        = level;
    saved_vaddr_next  = saved_vaddr;
    saved_access_next = saved_access;
    entry_addr_next   = entry_addr;

    if (s_func == sv39ptw_pkg::FUNC_REQ) begin
      if (level == sv39ptw_pkg::LVL_IDLE) begin
        r0_valid = 1'b1;
        r0.last  = 1'b1;
        if (!paging_enable) begin
          r0.kind = sv39ptw_pkg::KIND_DONE;
          r0.addr = s_va;
        end else begin
          saved_vaddr_next  = s_va;
          saved_access_next = s_acc;
          entry_addr_next   = root_addr;
          level_next        = sv39ptw_pkg::LVL_ROOT;
          r0.kind           = sv39ptw_pkg::KIND_READ;
          r0.addr           = root_addr;
        end
      end
    end else if (level != sv39ptw_pkg::LVL_IDLE) begin
      if (!s_ok || !s_data[sv39ptw_pkg::PTE_V]) begin
        r0_valid   = 1'b1;
        r0.kind    = sv39ptw_pkg::KIND_DONE;
        r0.addr    = saved_vaddr;
        r0.fault   = sv39ptw_pkg::FAULT_LOAD;
        r0.last    = 1'b1;
        level_next = sv39ptw_pkg::LVL_IDLE;
      end else if (level == sv39ptw_pkg::LVL_LEAF) begin
        leaf_hit = 1'b1;
      end else if (s_data[sv39ptw_pkg::PTE_X:sv39ptw_pkg::PTE_R] != 3'b000) begin
        if (level == sv39ptw_pkg::LVL_ROOT) begin
          // A leaf at the root level is not supported.
          r0_valid   = 1'b1;
          r0.kind    = sv39ptw_pkg::KIND_DONE;
          r0.addr    = saved_vaddr;
          r0.fault   = sv39ptw_pkg::FAULT_LOAD;
          r0.last    = 1'b1;
          level_next = sv39ptw_pkg::LVL_IDLE;
        end else begin
          // Megapage: low page-number bits come from the virtual address.
          leaf_hit = 1'b1;
          done_ppn = {ppn[43:9], saved_vaddr[20:12]};
        end
      end else begin
        entry_addr_next = next_addr;
        level_next      = (level == sv39ptw_pkg::LVL_ROOT) ? sv39ptw_pkg::LVL_MID
                                                           : sv39ptw_pkg::LVL_LEAF;
        r0_valid        = 1'b1;
        r0.kind         = sv39ptw_pkg::KIND_READ;
        r0.addr         = next_addr;
        r0.last         = 1'b1;
      end
    end

    // Leaf completion: fault, or write-back followed by the physical address.
    if (leaf_hit) begin
      level_next = sv39ptw_pkg::LVL_IDLE;
      r0_valid   = 1'b1;
      if (perm_fault) begin
        r0.kind  = sv39ptw_pkg::KIND_DONE;
        r0.addr  = saved_vaddr;
        r0.fault = perm_code;
        r0.last  = 1'b1;
      end else begin
        r0.kind  = sv39ptw_pkg::KIND_WRITE;
        r0.addr  = entry_addr;
        r0.wdata = new_pte;
        r1_valid = 1'b1;
        r1.kind  = sv39ptw_pkg::KIND_DONE;
        r1.addr  = {8'b0, done_ppn, saved_vaddr[11:0]};
        r1.last  = 1'b1;
      end
    end
  end

  // Walk state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= sv39ptw_pkg::LVL_IDLE;
      saved_vaddr  <= '0;
      saved_access <= '0;
      entry_addr   <= '0;
    end else if (fire) begin
      level        <= level_next;
      saved_vaddr  <= saved_vaddr_next;
      saved_access <= saved_access_next;
      entry_addr   <= entry_addr_next;
    end
  end

  sv39ptw_outq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push0    (fire && r0_valid),
    .data0    (r0),
    .push1    (fire && r1_valid),
    .data1    (r1),
    .space2   (space2),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (q_out)
  );

  assign out_kind   = q_out.kind;
  assign out_addr   = q_out.addr;
  assign write_data = q_out.wdata;
  assign fault_code = q_out.fault;
  assign last       = q_out.last;

endmodule

// ===== hw/rtl/sv39ptw_outq.sv =====
// Small result queue that accepts up to two results per cycle and delivers one.
module sv39ptw_outq #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push0,
  input  sv39ptw_pkg::result_t data0,
  input  logic                 push1,
  input  sv39ptw_pkg::result_t data1,
  output logic                 space2,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sv39ptw_pkg::result_t out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] LIMIT = CW'(DEPTH - 2);
  localparam logic [PW-1:0] LASTP = PW'(DEPTH - 1);

  sv39ptw_pkg::result_t entries [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [CW-1:0] count;
  logic [PW-1:0] tail1;
  logic [PW-1:0] tail2;
  logic [PW-1:0] head1;
  logic          pop;
  logic [CW-1:0] count_next;

  // Pointer increments with wrap at the queue depth.
  assign tail1 = (tail == LASTP) ? '0 : tail + 1'b1;
  assign tail2 = (tail1 == LASTP) ? '0 : tail1 + 1'b1;
  assign head1 = (head == LASTP) ? '0 : head + 1'b1;

  assign out_valid = (count != '0);
  assign out_data  = entries[head];
  assign pop       = out_valid && out_ready;
  assign space2    = (count <= LIMIT);

  always_comb begin
    count_next = count + CW'(push0) + CW'(push1) - CW'(pop);
  end

  // Storage writes; the second result lands behind the first.
  always_ff @(posedge clk) begin
    if (push0) begin
      entries[tail] <= data0;
    end
    if (push1) begin
      entries[tail1] <= data1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head1;
      end
      if (push0 && push1) begin
        tail <= tail2;
      end else if (push0) begin
        tail <= tail1;
      end
    end
  end

endmodule

// ===== test/sv39_page_table_walker_tb.sv =====
// Self-checking testbench for the Sv39 page-table walker: directed table, then random walks.
module sv39_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sv39ptw_pkg::*;

  // Access kind outside the three named ones: no permission check is made.
  localparam logic [1:0] ACC_UNCHECKED = 2'd3;

  localparam logic [63:0] ONES64   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [43:0] ROOT_MAX = 44'hFFF_FFFF_FFFF;
  localparam logic [63:0] VA_A     = 64'h8000_0040_0BAD_F123;
  localparam logic [63:0] VA_B     = 64'h0000_007F_C030_1ABC;
  localparam logic [63:0] VA_C     = 64'hFFFF_FFC0_2468_ACE0;
  localparam logic [63:0] PTR_PTE  = 64'h0000_0000_0000_0801;

  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CYCLE_LIMIT     = 500_000;

  typedef struct packed {
    logic        func;
    logic [63:0] vaddr;
    logic [1:0]  acc;
    logic [63:0] pte;
    logic        ok;
  } walk_item_t;

  typedef struct packed {
    logic        paging;
    logic [43:0] root;
    walk_item_t  item;
    logic        fixed_exp;
    result_t     exp;
  } stim_row_t;

  localparam result_t NO_EXP = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [43:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [63:0] virt_addr = '0;
  logic [1:0]  access_kind = '0;
  logic [63:0] mem_data = '0;
  logic        mem_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [63:0] out_addr;
  logic [63:0] write_data;
  logic [1:0]  fault_code;
  logic        last;

  // Walker state and configuration as the testbench sees them.
  level_t      walk_lvl = LVL_IDLE;
  logic [63:0] saved_va = '0;
  logic [1:0]  saved_acc = '0;
  logic [63:0] walk_entry = '0;
  logic        paging_on = 1'b0;
  logic [43:0] root_page_num = '0;

  result_t     step_results[$];
  result_t     awaited_results[$];
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          sink_mode = 0;
  int          sink_mode_left = 0;

  sv39_page_table_walker i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void put_result(logic [1:0] kind, logic [63:0] addr, logic [63:0] wdata,
                                     logic [1:0] fault, logic lst);
    result_t r;
    r.kind  = kind;
    r.addr  = addr;
    r.wdata = wdata;
    r.fault = fault;
    r.last  = lst;
    step_results.push_back(r);
  endfunction

  function automatic void end_with_fault(logic [1:0] code);
    put_result(KIND_DONE, saved_va, '0, code, 1'b1);
    walk_lvl = LVL_IDLE;
  endfunction

  // Leaf handling: permission check, then A/D write-back and the physical address.
  function automatic void end_with_leaf(logic [63:0] pte, logic [43:0] ppn);
    logic [63:0] upd;
    if (saved_acc == ACC_FETCH && !pte[PTE_X]) end_with_fault(FAULT_INST);
    else if (saved_acc == ACC_LOAD && !pte[PTE_R]) end_with_fault(FAULT_LOAD);
    else if (saved_acc == ACC_STORE && !pte[PTE_W]) end_with_fault(FAULT_STORE);
    else begin
      upd = pte;
      upd[PTE_A] = 1'b1;
      if (saved_acc == ACC_STORE) upd[PTE_D] = 1'b1;
      put_result(KIND_WRITE, walk_entry, upd, FAULT_NONE, 1'b0);
      put_result(KIND_DONE, {8'b0, ppn, saved_va[11:0]}, '0, FAULT_NONE, 1'b1);
      walk_lvl = LVL_IDLE;
    end
  endfunction

  // Expected results of one accepted item; updates the walk state.
  function automatic void translate_item(walk_item_t it);
    logic [43:0] ppn;
    step_results.delete();
    if (it.func == FUNC_REQ) begin
      if (walk_lvl != LVL_IDLE) return;
      if (!paging_on) begin
        put_result(KIND_DONE, it.vaddr, '0, FAULT_NONE, 1'b1);
        return;
      end
      saved_va   = it.vaddr;
      saved_acc  = it.acc;
      walk_entry = {8'b0, root_page_num, 12'b0} + {52'b0, it.vaddr[38:30], 3'b0};
      walk_lvl   = LVL_ROOT;
      put_result(KIND_READ, walk_entry, '0, FAULT_NONE, 1'b1);
      return;
    end
    // Memory response: ignored unless a walk is in progress.
    if (walk_lvl == LVL_IDLE) return;
    if (!it.ok || !it.pte[PTE_V]) begin
      end_with_fault(FAULT_LOAD);
      return;
    end
    ppn = it.pte[53:10];
    if (walk_lvl == LVL_LEAF) end_with_leaf(it.pte, ppn);
    else if (it.pte[PTE_X:PTE_R] != 3'b000) begin
      if (walk_lvl == LVL_ROOT) end_with_fault(FAULT_LOAD);
      else end_with_leaf(it.pte, {ppn[43:9], saved_va[20:12]});
    end else begin
      if (walk_lvl == LVL_ROOT) begin
        walk_entry = {8'b0, ppn, 12'b0} + {52'b0, saved_va[29:21], 3'b0};
        walk_lvl   = LVL_MID;
      end else begin
        walk_entry = {8'b0, ppn, 12'b0} + {52'b0, saved_va[20:12], 3'b0};
        walk_lvl   = LVL_LEAF;
      end
      put_result(KIND_READ, walk_entry, '0, FAULT_NONE, 1'b1);
    end
  endfunction

  // Random PTE shaped by the current level, so that many walks go deep and succeed.
  function automatic logic [63:0] shape_pte();
    logic [63:0] p;
    int ptr_pct;
    p = rand64();
    if ($urandom_range(0, 9) == 0) begin
      p[PTE_V] = 1'b0;
      return p;
    end
    p[PTE_V] = 1'b1;
    ptr_pct = (walk_lvl == LVL_ROOT) ? 80 : (walk_lvl == LVL_MID) ? 50 : 10;
    if ($urandom_range(0, 99) < ptr_pct) p[PTE_X:PTE_R] = 3'b000;
    else begin
      if (p[PTE_X:PTE_R] == 3'b000) p[PTE_R] = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        case (saved_acc)
          ACC_FETCH: p[PTE_X] = 1'b1;
          ACC_LOAD:  p[PTE_R] = 1'b1;
          ACC_STORE: p[PTE_W] = 1'b1;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // Mostly well-formed traffic for the walk state, with some requests and responses that
  // arrive at the wrong time.
  function automatic walk_item_t make_item();
    walk_item_t it;
    int roll;
    it.func  = FUNC_REQ;
    it.vaddr = rand64();
    it.acc   = ($urandom_range(0, 19) == 0) ? ACC_UNCHECKED : 2'($urandom_range(0, 2));
    it.pte   = rand64();
    it.ok    = ($urandom_range(0, 14) != 0);
    roll = $urandom_range(0, 99);
    if (walk_lvl == LVL_IDLE) begin
      if (roll < 8) it.func = FUNC_RESP;
    end else if (roll >= 10) begin
      it.func = FUNC_RESP;
      it.pte  = shape_pte();
    end
    return it;
  endfunction

  // Drive one item and hold it until the transfer; keep selects the predicted results.
  task automatic send_item(input walk_item_t it, input logic keep);
    func        <= it.func;
    virt_addr   <= it.vaddr;
    access_kind <= it.acc;
    mem_data    <= it.pte;
    mem_ok      <= it.ok;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    translate_item(it);
    if (keep) foreach (step_results[k]) awaited_results.push_back(step_results[k]);
  endtask

  // Sender bursts of random length, with random gaps between them.
  task automatic sender_pace();
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // End any walk with a failed read, then wait until every result has come out.
  task automatic settle_walker();
    walk_item_t abort_it;
    if (walk_lvl != LVL_IDLE) begin
      abort_it = '0;
      abort_it.func = FUNC_RESP;
      send_item(abort_it, 1'b1);
    end
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [43:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_PAGING) paging_on = val[0];
    else root_page_num = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every output transfer with the oldest expected result.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d addr %h",
                 $time, out_kind, out_addr);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("out_kind", 64'(want.kind), 64'(out_kind));
        check_field("out_addr", want.addr, out_addr);
        check_field("write_data", want.wdata, write_data);
        check_field("fault_code", 64'(want.fault), 64'(fault_code));
        check_field("last", 64'(want.last), 64'(last));
      end
    end
  end

  // Receiver stalls: modes of random length, from always ready to heavy back-pressure.
  always @(posedge clk) begin
    if (sink_mode_left == 0) begin
      sink_mode      <= $urandom_range(0, 3);
      sink_mode_left <= $urandom_range(20, 150);
    end else begin
      sink_mode_left <= sink_mode_left - 1;
    end
    case (sink_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 2) == 0);
      default: out_ready <= ((sink_mode_left % 5) < 2);
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sv39_page_table_walker_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t  row;
    walk_item_t it;
    logic       pg;
    logic [43:0] rt;
    int         produced;

    // Directed rows: passthrough after reset, faults of every kind, superpages, deep walks.
    directed_rows = '{
      '{1'b0, 44'd0, '{FUNC_REQ, 64'd0, ACC_FETCH, 64'd0, 1'b1},
        1'b1, '{KIND_DONE, 64'd0, 64'd0, FAULT_NONE, 1'b1}},
      '{1'b0, 44'd0, '{FUNC_REQ, ONES64, ACC_STORE, 64'd0, 1'b1},
        1'b1, '{KIND_DONE, ONES64, 64'd0, FAULT_NONE, 1'b1}},
      '{1'b0, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, ONES64, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, ROOT_MAX, '{FUNC_REQ, ONES64, ACC_LOAD, 64'd0, 1'b1},
        1'b1, '{KIND_READ, 64'h00FF_FFFF_FFFF_FFF8, 64'd0, FAULT_NONE, 1'b1}},
      '{1'b1, ROOT_MAX, '{FUNC_REQ, 64'd0, ACC_STORE, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, ROOT_MAX, '{FUNC_RESP, 64'd0, ACC_FETCH, ONES64, 1'b0},
        1'b1, '{KIND_DONE, ONES64, 64'd0, FAULT_LOAD, 1'b1}},
      '{1'b1, ROOT_MAX, '{FUNC_REQ, VA_A, ACC_FETCH, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, ROOT_MAX, '{FUNC_RESP, 64'd0, ACC_FETCH, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1},
        1'b1, '{KIND_DONE, VA_A, 64'd0, FAULT_LOAD, 1'b1}},
      '{1'b1, ROOT_MAX, '{FUNC_REQ, VA_A, ACC_LOAD, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, ROOT_MAX, '{FUNC_RESP, 64'd0, ACC_FETCH, 64'h0000_0000_0000_0403, 1'b1},
        1'b1, '{KIND_DONE, VA_A, 64'd0, FAULT_LOAD, 1'b1}},
      '{1'b1, 44'd0, '{FUNC_REQ, VA_B, ACC_STORE, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, PTR_PTE, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, 64'hFFC0_0000_0000_0C01, 1'b1},
        1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, 64'h003F_FFFF_FFFF_FC0F, 1'b1},
        1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_REQ, VA_B, ACC_FETCH, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, PTR_PTE, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, 64'h0000_0000_1234_5403, 1'b1},
        1'b1, '{KIND_DONE, VA_B, 64'd0, FAULT_INST, 1'b1}},
      '{1'b1, 44'd0, '{FUNC_REQ, VA_C, ACC_STORE, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, PTR_PTE, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, 64'h0000_0000_0000_040B, 1'b1},
        1'b1, '{KIND_DONE, VA_C, 64'd0, FAULT_STORE, 1'b1}},
      '{1'b1, 44'd0, '{FUNC_REQ, VA_C, ACC_UNCHECKED, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, PTR_PTE, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, 64'h0000_1234_5678_9C03, 1'b1},
        1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_REQ, VA_A, ACC_LOAD, 64'd0, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, PTR_PTE, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, PTR_PTE, 1'b1}, 1'b0, NO_EXP},
      '{1'b1, 44'd0, '{FUNC_RESP, 64'd0, ACC_FETCH, PTR_PTE, 1'b1},
        1'b1, '{KIND_DONE, VA_A, 64'd0, FAULT_LOAD, 1'b1}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the registers change only between rows with the walker drained.
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.paging !== paging_on || row.root !== root_page_num) begin
        settle_walker();
        cfg_write(CFG_ROOT, row.root);
        cfg_write(CFG_PAGING, 44'(row.paging));
      end
      send_item(row.item, !row.fixed_exp);
      if (row.fixed_exp) awaited_results.push_back(row.exp);
      sender_pace();
    end

    // Random phases, each with its own setting; the sender drains fully between them.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_walker();
      case (ph)
        0: begin pg = 1'b1; rt = '0; end
        1: begin pg = 1'b1; rt = ROOT_MAX; end
        2: begin pg = 1'b0; rt = 44'(rand64()); end
        default: begin pg = ($urandom_range(0, 4) != 0); rt = 44'(rand64()); end
      endcase
      cfg_write(CFG_ROOT, rt);
      cfg_write(CFG_PAGING, 44'(pg));
      produced = 0;
      while (produced < ITEMS_PER_PHASE) begin
        it = make_item();
        send_item(it, 1'b1);
        if (step_results.size() != 0) produced++;
        sender_pace();
      end
    end

    settle_walker();
    if (mismatch_count == 0) $display("sv39_page_table_walker_tb passed");
    else $display("sv39_page_table_walker_tb failed");
    $finish;
  end

endmodule
